>>> rtl/mexp_pkg.sv
package mexp_pkg;

  // Default operand width
  localparam int unsigned MEXP_WIDTH = 16;

  // Multiplication selector: what goes into the shift-add unit and where it lands
  typedef enum logic [1:0] {
    OP_RED = 2'd0,  // base mod m (1 * base)
    OP_ACC = 2'd1,  // acc * sq
    OP_SQ  = 2'd2   // sq * sq
  } mul_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;   // capture request operands, acc <= 1
    logic    start;  // start a modular multiplication
    mul_op_t op;     // which multiplication
    logic    shift;  // shift exponent right by one
    logic    emit;   // move acc into the output register
  } mexp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_done;  // last step of a multiplication this cycle
    logic exp_zero;  // no exponent bits left
    logic exp_lsb;   // current exponent bit
    logic out_free;  // output register can take a result
  } mexp_stat_t;

endpackage

>>> rtl/modular_exponentiation_top.sv
// Modular exponentiation: power = base ** exponent mod modulus, right-to-left
// square-and-multiply over a bit-serial shift-add modular multiplier.
// Channels:
//   s_axis  - request: base and exponent. Accepted when s_axis_tvalid and
//             s_axis_tready are high; tready is high only while the block is idle.
//   m_axis  - one result per request, held in an output register until taken.
//   cfg     - modulus write, always ready; write only while the block is idle.
// Timing: one request at a time. The multiplier does one bit per cycle. An accepted
// request runs the base reduction, then, per exponent bit up to its highest set bit,
// a square plus a multiplication when the bit is set, then the output step; tready
// returns with the result, so the next request can follow it.
// A zero exponent gives 1; a zero modulus makes products wrap to WIDTH bits.
// Reset sets the modulus to 1 and clears the output valid. A stalled receiver
// holds the result; the block then finishes the next request and waits for the
// output register before going idle again.
module modular_exponentiation_top
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = MEXP_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // base [WIDTH-1:0], exponent [2*WIDTH-1:WIDTH], zero padded to bytes
  input  logic [((2*WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // power [WIDTH-1:0], zero padded to bytes
  output logic [((WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [WIDTH-1:0]                  cfg_data
);

  localparam int unsigned OUT_W = ((WIDTH + 7) / 8) * 8;

  mexp_cmd_t        cmd;
  mexp_stat_t       stat;
  logic [WIDTH-1:0] power;

  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_modulus (cfg_data),
    .in_base     (s_axis_tdata[WIDTH-1:0]),
    .in_exponent (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_power   (power)
  );

  assign m_axis_tdata = OUT_W'(power);

endmodule

>>> rtl/mexp_ctrl.sv
module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mexp_stat_t stat,
  output mexp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_WAIT,
    S_DECIDE,
    S_ACC_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_OUT
  } state_t;

  state_t state, state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_RED;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RED_GO;
        end
      end
      S_RED_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_RED;
        state_next = S_RED_WAIT;
      end
      S_RED_WAIT: begin
        if (stat.mul_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.exp_zero) begin
          state_next = S_OUT;
        end else if (stat.exp_lsb) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_ACC;
          state_next = S_ACC_WAIT;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = OP_SQ;
          state_next = S_SQ_WAIT;
        end
      end
      S_ACC_WAIT: begin
        if (stat.mul_done) state_next = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_SQ;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (stat.mul_done) begin
          cmd.shift  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/mexp_dp.sv
module mexp_dp
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = MEXP_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_modulus,
  input  logic [WIDTH-1:0] in_base,
  input  logic [WIDTH-1:0] in_exponent,
  input  mexp_cmd_t        cmd,
  output mexp_stat_t       stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_power
);

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] acc, sq, e;
  logic [WIDTH-1:0] ma, mb, r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  mul_op_t          op;

  logic [WIDTH:0]   m_ext, dbl, dred, sum, sred;
  logic [WIDTH-1:0] r_next;
  logic             last_step;

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(1);
    end else if (cfg_we) begin
      modulus <= cfg_modulus;
    end
  end

  // One shift-add step, MSB of b first: r = 2r mod m, then + a mod m on a set bit.
  // A zero modulus subtracts nothing, so the result simply wraps to WIDTH bits.
  always_comb begin
    m_ext  = {1'b0, modulus};
    dbl    = {r, 1'b0};
    dred   = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum    = {1'b0, dred[WIDTH-1:0]} + {1'b0, ma};
    sred   = (sum >= m_ext) ? (sum - m_ext) : sum;
    r_next = mb[WIDTH-1] ? sred[WIDTH-1:0] : dred[WIDTH-1:0];
  end

  assign last_step = busy && (cnt == '0);

  // Multiplier sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (last_step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r   <= '0;
      cnt <= CNT_LAST;
      op  <= cmd.op;
      case (cmd.op)
        OP_RED: begin
          ma <= WIDTH'(1);
          mb <= sq;
        end
        OP_ACC: begin
          ma <= acc;
          mb <= sq;
        end
        OP_SQ: begin
          ma <= sq;
          mb <= sq;
        end
        default: begin
          ma <= sq;
          mb <= sq;
        end
      endcase
    end else if (busy) begin
      r   <= r_next;
      mb  <= {mb[WIDTH-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  // Operand registers: load on request, write back finished products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq  <= in_base;
      e   <= in_exponent;
      acc <= WIDTH'(1);
    end else begin
      if (last_step) begin
        case (op)
          OP_ACC:  acc <= r_next;
          OP_RED:  sq  <= r_next;
          OP_SQ:   sq  <= r_next;
          default: sq  <= r_next;
        endcase
      end
      if (cmd.shift) e <= {1'b0, e[WIDTH-1:1]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_power <= acc;
  end

  // Status to controller
  always_comb begin
    stat.mul_done = last_step;
    stat.exp_zero = (e == '0);
    stat.exp_lsb  = e[0];
    stat.out_free = !out_valid || out_ready;
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mexp_pkg::*;

  localparam int W = MEXP_WIDTH;
  localparam int IN_BITS = ((2 * W + 7) / 8) * 8;
  localparam int OUT_BITS = ((W + 7) / 8) * 8;
  localparam int NUM_VECTORS = 24;
  localparam int PHASE_ITEMS = 180;
  localparam int CHUNK_ITEMS = 45;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // base, exponent (lowest bits first), zero padded
  logic [IN_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // power, zero padded
  logic [OUT_BITS-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [W-1:0] cfg_data = '0;

  // One directed row: modulus in force, operands, and a hand-read answer if known
  typedef struct packed {
    logic [W-1:0] modulus;
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic         known;
    logic [W-1:0] power;
  } vector_t;

  vector_t vectors [NUM_VECTORS] = '{
    // reset modulus of 1: only a zero exponent escapes reduction
    '{16'd1,     16'd0,     16'd0,     1'b1, 16'd1},
    '{16'd1,     16'd65535, 16'd65535, 1'b1, 16'd0},
    '{16'd1,     16'd7,     16'd1,     1'b1, 16'd0},
    // largest modulus
    '{16'd65535, 16'd0,     16'd0,     1'b1, 16'd1},
    '{16'd65535, 16'd0,     16'd1,     1'b1, 16'd0},
    '{16'd65535, 16'd65535, 16'd1,     1'b1, 16'd0},
    '{16'd65535, 16'd65534, 16'd1,     1'b1, 16'd65534},
    '{16'd65535, 16'd1,     16'd65535, 1'b1, 16'd1},
    '{16'd65535, 16'd65534, 16'd2,     1'b1, 16'd1},
    '{16'd65535, 16'd65534, 16'd65535, 1'b1, 16'd65534},
    '{16'd65535, 16'd2,     16'd16,    1'b1, 16'd1},
    '{16'd65535, 16'd12345, 16'd65535, 1'b0, 16'd0},
    '{16'd65535, 16'h8000,  16'hffff,  1'b0, 16'd0},
    // zero modulus: products wrap to the operand width
    '{16'd0,     16'd2,     16'd15,    1'b1, 16'd32768},
    '{16'd0,     16'd2,     16'd16,    1'b1, 16'd0},
    '{16'd0,     16'd65535, 16'd2,     1'b1, 16'd1},
    '{16'd0,     16'd65535, 16'd65535, 1'b1, 16'd65535},
    '{16'd0,     16'd3,     16'd0,     1'b1, 16'd1},
    '{16'd0,     16'haaaa,  16'h5555,  1'b0, 16'd0},
    // smallest nontrivial modulus, then a prime
    '{16'd2,     16'd3,     16'd65535, 1'b1, 16'd1},
    '{16'd2,     16'd4,     16'd7,     1'b1, 16'd0},
    '{16'd65521, 16'd2,     16'd65520, 1'b1, 16'd1},
    '{16'd65521, 16'd12345, 16'd54321, 1'b0, 16'd0},
    '{16'd65521, 16'h5555,  16'haaaa,  1'b0, 16'd0}
  };

  logic [W-1:0] expected_powers [$];
  logic [W-1:0] modulus_now = 16'd1;
  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  modular_exponentiation_top #(.WIDTH(W)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // a * b mod m; a zero modulus just wraps
  function automatic logic [W-1:0] mod_product(input logic [W-1:0] a, b, m);
    logic [2*W-1:0] prod;
    prod = a * b;
    if (m == 0) return prod[W-1:0];
    return W'(prod % m);
  endfunction

  // base ** exponent mod m, squaring from the low exponent bit up
  function automatic logic [W-1:0] predict_power(input logic [W-1:0] b, e, m);
    logic [W-1:0] sq;
    logic [W-1:0] acc;
    int i;
    sq = (m != 0) ? b % m : b;
    acc = 1;
    for (i = 0; i < W; i++) begin
      if (e[i]) acc = mod_product(acc, sq, m);
      sq = mod_product(sq, sq, m);
    end
    return acc;
  endfunction

  // Receiver backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: power=%0d", m_axis_tdata[W-1:0]);
      end else begin
        if (m_axis_tdata[W-1:0] !== expected_powers[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("power mismatch: expected %0d got %0d",
                     expected_powers[0], m_axis_tdata[W-1:0]);
        end
        void'(expected_powers.pop_front());
      end
    end
  end

  // Cycles since the last handshake on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("[modular_exponentiation_top] ERROR");
    $finish;
  end

  // Offer one request; valid stays high into the next request unless the sender idles
  task automatic send_request(input logic [W-1:0] b, e, input logic known,
                              input logic [W-1:0] power);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {e, b};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_powers.push_back(known ? power : predict_power(b, e, modulus_now));
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_powers.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    modulus_now = m;
  endtask

  function automatic logic [W-1:0] pick_modulus();
    case ($urandom_range(7))
      0: return 1;
      1: return {W{1'b1}};
      2: return 0;
      3: return W'($urandom_range(255, 2));
      default: return W'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
    case ($urandom_range(9))
      0: return 0;
      1: return {W{1'b1}};
      2: return m - 1;
      3: return 1;
      default: return W'($urandom());
    endcase
  endfunction

  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(9))
      0: return 0;
      1: return W'($urandom_range(15));
      2: return {W{1'b1}};
      default: return W'($urandom());
    endcase
  endfunction

  initial begin
    int k;
    int phase;
    int n;
    logic [W-1:0] b;
    logic [W-1:0] e;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; the modulus changes only once the block has gone quiet
    for (k = 0; k < NUM_VECTORS; k++) begin
      if (vectors[k].modulus != modulus_now) begin
        wait_results();
        write_modulus(vectors[k].modulus);
      end
      send_request(vectors[k].base, vectors[k].exponent, vectors[k].known,
                   vectors[k].power);
    end

    // Random requests in three idling phases, new modulus every chunk
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 33;
          recv_idle = 82;
        end
        1: begin
          send_idle = 82;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % CHUNK_ITEMS == 0) begin
          wait_results();
          write_modulus(pick_modulus());
        end
        b = pick_base(modulus_now);
        e = pick_exponent();
        send_request(b, e, 1'b0, '0);
      end
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_powers.size() == 0)
      $display("[modular_exponentiation_top] OK");
    else
      $display("[modular_exponentiation_top] ERROR");
    $finish;
  end

endmodule
